FILE: sv/dect_slot_table_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// Slot table tracker assertion macros
// Shared concurrent assertion forms, clocked by clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECT_SLOT_TABLE_TRACKER_CORE_DEFINES_SVH
`define DECT_SLOT_TABLE_TRACKER_CORE_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define DSTT_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("dstt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSTT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dstt assertion failed");

`endif

FILE: sv/dstt_pkg.sv
// ----------------------------------------------------------------------------
// Slot table tracker package
// Shared types and constants of the slot table tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dstt_pkg;

   localparam int SLOT_FIELD_W = 5;
   localparam int BEARER_W     = 4;
   localparam int INFO_SLOTS   = 16;
   localparam int BITMAP_W     = 12;
   localparam int MASK_W       = 24;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = 1;
   localparam int QUEUE_CNT_W  = 2;

   localparam logic [7:0]  TAIL_TYPE_MASK = 8'he0;
   localparam logic [7:0]  TAIL_TYPE_P    = 8'he0;
   localparam logic [7:0]  TAIL_TYPE_Q    = 8'h80;
   localparam logic [7:0]  PAGE_HEAD_MASK = 8'h70;
   localparam logic [7:0]  PAGE_HEAD_ZERO = 8'h00;
   localparam logic [7:0]  PAGE_HEAD_ONE  = 8'h10;
   localparam logic [3:0]  Q_HEAD_STATIC  = 4'h0;
   localparam logic [3:0]  INFO_BEARER    = 4'h2;
   localparam logic [3:0]  INFO_BITMAP    = 4'h1;

   localparam logic [7:0]  ERROR_LIMIT_RESET     = 8'd32;
   localparam logic [5:0]  LAST_CHANNEL_RESET    = 6'd9;
   localparam logic [15:0] FIXED_PART_SYNC_RESET = 16'he98a;

   typedef enum logic [1:0] {
      CMD_PACKET = 2'd0,
      CMD_ERROR  = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_ERROR_LIMIT     = 2'd0,
      CSR_LAST_CHANNEL    = 2'd1,
      CSR_FIXED_PART_SYNC = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ERROR,
      KIND_TICK,
      KIND_PACKET,
      KIND_BEARER,
      KIND_BITMAP,
      KIND_SCAN_CHANNEL
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [BEARER_W-1:0]     bear_slot;
      logic [BITMAP_W-1:0]     bitmap;
      logic [7:0]              data;
   } op_type;

   typedef struct packed {
      logic [7:0]  error_limit;
      logic [5:0]  last_channel;
      logic [15:0] fixed_part_sync;
   } cfg_type;

endpackage

FILE: sv/dstt_req_if.sv
// ----------------------------------------------------------------------------
// Slot table tracker event channel
// Valid/ready channel carrying one event per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dstt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [4:0] slot;
   logic [7:0] sync_high;
   logic [7:0] sync_low;
   logic [7:0] a_header;
   logic [7:0] tail_head;
   logic [7:0] info_byte;
   logic [7:0] info_data;

   modport source (output valid, cmd, slot, sync_high, sync_low, a_header, tail_head,
                   info_byte, info_data, input ready);
   modport sink (input valid, cmd, slot, sync_high, sync_low, a_header, tail_head,
                 info_byte, info_data, output ready);
endinterface

FILE: sv/dstt_rsp_if.sv
// ----------------------------------------------------------------------------
// Slot table tracker result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dstt_rsp_if;
   logic        valid;
   logic        ready;
   logic        changed;
   logic        slot_active;
   logic        slot_scanning;
   logic [7:0]  slot_channel;
   logic [23:0] update_mask;

   modport source (output valid, changed, slot_active, slot_scanning, slot_channel,
                   update_mask, input ready);
   modport sink (input valid, changed, slot_active, slot_scanning, slot_channel,
                 update_mask, output ready);
endinterface

FILE: sv/dstt_csr_if.sv
// ----------------------------------------------------------------------------
// Slot table tracker register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dstt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dstt_front.sv
// ----------------------------------------------------------------------------
// Slot table tracker front end
// Accepts events and classifies each event into a table operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dstt_front #(
   parameter int HALF_FRAME = 12
) (
   input  dstt_pkg::cfg_type cfg,
   dstt_req_if.sink          req,
   input  logic              full,
   output logic              push,
   output dstt_pkg::op_type  op
);
   import dstt_pkg::*;

   logic [BEARER_W-1:0] mod_tab [INFO_SLOTS];
   logic                sync_match;
   logic [7:0]          page_head;

   for (genvar v = 0; v < INFO_SLOTS; v++) begin : g_mod
      localparam int ModValue = v % HALF_FRAME;
      assign mod_tab[v] = BEARER_W'(ModValue);
   end

   assign req.ready  = !full;
   assign push       = req.valid && !full;
   assign sync_match = (req.sync_high == cfg.fixed_part_sync[15:8]) &&
                       (req.sync_low == cfg.fixed_part_sync[7:0]);
   assign page_head  = req.tail_head & PAGE_HEAD_MASK;

   always_comb begin
      op.kind      = KIND_NONE;
      op.slot      = req.slot;
      op.bear_slot = mod_tab[req.info_byte[3:0]];
      op.bitmap    = {req.info_byte[3:0], req.info_data};
      op.data      = req.info_data;
      case (cmd_type'(req.cmd))
         CMD_PACKET: begin
            op.kind = KIND_PACKET;
            if (sync_match) begin
               if ((req.a_header & TAIL_TYPE_MASK) == TAIL_TYPE_P) begin
                  if (page_head == PAGE_HEAD_ZERO || page_head == PAGE_HEAD_ONE) begin
                     if (req.info_byte[7:4] == INFO_BEARER) begin
                        op.kind = KIND_BEARER;
                     end else if (req.info_byte[7:4] == INFO_BITMAP) begin
                        op.kind = KIND_BITMAP;
                     end
                  end
               end else if ((req.a_header & TAIL_TYPE_MASK) == TAIL_TYPE_Q) begin
                  if (req.tail_head[7:4] == Q_HEAD_STATIC) begin
                     op.kind = KIND_SCAN_CHANNEL;
                  end
               end
            end
         end
         CMD_ERROR: op.kind = KIND_ERROR;
         CMD_TICK:  op.kind = KIND_TICK;
         default:   op.kind = KIND_NONE;
      endcase
   end

endmodule

FILE: sv/dstt_queue.sv
// ----------------------------------------------------------------------------
// Slot table tracker operation queue
// Two-entry queue decoupling the front end from the table back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dect_slot_table_tracker_core_defines.svh"

module dstt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dstt_pkg::op_type wr_op,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output dstt_pkg::op_type rd_op
);
   import dstt_pkg::*;

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign rd_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_op;
      end
   end

   `DSTT_ASSERT_ALWAYS(a_count_bound, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `DSTT_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: sv/dstt_back.sv
// ----------------------------------------------------------------------------
// Slot table tracker back end
// Holds the slot table, applies one operation per cycle unless the result channel stalls, registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dect_slot_table_tracker_core_defines.svh"

module dstt_back #(
   parameter int HALF_FRAME = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  dstt_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  dstt_pkg::op_type  op,
   output logic              pop,
   dstt_rsp_if.source        rsp
);
   import dstt_pkg::*;

   localparam int NSLOTS = 2 * HALF_FRAME;
   localparam int SLOT_W = $clog2(NSLOTS);

   logic [NSLOTS-1:0] active_ff, active_in;
   logic [NSLOTS-1:0] scan_ff, scan_in;
   logic [NSLOTS-1:0] upd_ff, upd_in;
   logic [7:0]        chan_ff [NSLOTS];
   logic [7:0]        chan_in [NSLOTS];
   logic [7:0]        err_ff [NSLOTS];
   logic [7:0]        err_in [NSLOTS];

   logic              rsp_valid_ff;
   logic              changed_ff, changed_in;
   logic              slot_active_ff, slot_active_in;
   logic              slot_scanning_ff, slot_scanning_in;
   logic [7:0]        slot_channel_ff, slot_channel_in;
   logic [MASK_W-1:0] mask_ff, mask_in;

   logic              addr_ok;
   logic [SLOT_W-1:0] addr_idx;
   logic              addr_scan;
   logic              is_packet;
   logic [7:0]        last_chan;

   assign pop       = q_valid && (!rsp_valid_ff || rsp.ready);
   assign addr_ok   = {1'b0, op.slot} < (SLOT_FIELD_W + 1)'(NSLOTS);
   assign addr_idx  = op.slot[SLOT_W-1:0];
   assign addr_scan = addr_ok && scan_ff[addr_idx];
   assign last_chan = {2'b00, cfg.last_channel};
   assign is_packet = op.kind == KIND_PACKET || op.kind == KIND_BEARER ||
                      op.kind == KIND_BITMAP || op.kind == KIND_SCAN_CHANNEL;

   always_comb begin
      int         mod_s;
      int         partner_s;
      logic       hit;
      logic       pair;
      logic [8:0] inc_v;
      logic [7:0] err_v;
      active_in  = active_ff;
      scan_in    = scan_ff;
      upd_in     = upd_ff;
      chan_in    = chan_ff;
      err_in     = err_ff;
      changed_in = 1'b0;
      for (int s = 0; s < NSLOTS; s++) begin
         mod_s     = (s >= HALF_FRAME) ? s - HALF_FRAME : s;
         partner_s = (s >= HALF_FRAME) ? s - HALF_FRAME : s + HALF_FRAME;
         hit       = op.slot == SLOT_FIELD_W'(s);
         pair      = op.slot == SLOT_FIELD_W'(partner_s);
         inc_v     = {1'b0, chan_ff[s]} + 9'd1;
         err_v     = (err_ff[s] == 8'hff) ? err_ff[s] : err_ff[s] + 8'd1;
         if (is_packet && addr_scan && (hit || pair)) begin
            scan_in[s] = 1'b0;
            chan_in[s] = (chan_ff[s] == 8'd0) ? last_chan : chan_ff[s] - 8'd1;
            err_in[s]  = 8'd0;
            upd_in[s]  = 1'b1;
         end
         case (op.kind)
            KIND_BEARER: begin
               if (op.bear_slot == BEARER_W'(mod_s)) begin
                  active_in[s] = 1'b1;
                  chan_in[s]   = {2'b00, op.data[5:0]};
                  scan_in[s]   = 1'b0;
                  err_in[s]    = 8'd0;
                  upd_in[s]    = 1'b1;
               end
               changed_in = 1'b1;
            end
            KIND_BITMAP: begin
               if (mod_s < BITMAP_W) begin
                  if (op.bitmap[BITMAP_W-1-mod_s] && !active_in[s]) begin
                     active_in[s] = 1'b1;
                     chan_in[s]   = 8'd0;
                     scan_in[s]   = 1'b1;
                     err_in[s]    = 8'd0;
                     upd_in[s]    = 1'b1;
                     changed_in   = 1'b1;
                  end
               end
            end
            KIND_SCAN_CHANNEL: begin
               if (active_in[s] && scan_in[s]) begin
                  chan_in[s] = op.data;
                  upd_in[s]  = 1'b1;
                  changed_in = 1'b1;
               end
            end
            KIND_TICK: begin
               if (active_ff[s] && scan_ff[s]) begin
                  chan_in[s] = (inc_v > {1'b0, last_chan}) ? 8'd0 : inc_v[7:0];
                  upd_in[s]  = 1'b1;
                  changed_in = 1'b1;
               end
            end
            KIND_ERROR: begin
               if (hit) begin
                  err_in[s] = err_v;
                  if (!scan_ff[s] && err_v > cfg.error_limit) begin
                     active_in[s] = 1'b0;
                     upd_in[s]    = 1'b1;
                     changed_in   = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < MASK_W; g++) begin : g_mask
      if (g < NSLOTS) begin : g_slot
         assign mask_in[g] = upd_in[g];
      end else begin : g_none
         assign mask_in[g] = 1'b0;
      end
   end

   always_comb begin
      slot_active_in   = addr_ok && active_in[addr_idx];
      slot_scanning_in = addr_ok && scan_in[addr_idx];
      slot_channel_in  = addr_ok ? chan_in[addr_idx] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         scan_ff      <= '0;
         upd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NSLOTS; s++) begin
            chan_ff[s] <= 8'd0;
            err_ff[s]  <= 8'd0;
         end
      end else begin
         if (pop) begin
            active_ff <= active_in;
            scan_ff   <= scan_in;
            upd_ff    <= upd_in;
            chan_ff   <= chan_in;
            err_ff    <= err_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         changed_ff       <= changed_in;
         slot_active_ff   <= slot_active_in;
         slot_scanning_ff <= slot_scanning_in;
         slot_channel_ff  <= slot_channel_in;
         mask_ff          <= mask_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.changed       = changed_ff;
   assign rsp.slot_active   = slot_active_ff;
   assign rsp.slot_scanning = slot_scanning_ff;
   assign rsp.slot_channel  = slot_channel_ff;
   assign rsp.update_mask   = mask_ff;

   `DSTT_ASSERT_ALWAYS(a_scan_implies_active, (scan_ff & ~active_ff) == '0)
   `DSTT_ASSERT_NEXT(a_pop_loads_result, pop, rsp_valid_ff)

endmodule

FILE: sv/dect_slot_table_tracker_core.sv
// ----------------------------------------------------------------------------
// Slot table tracker core
// Path: an accepted event is written into the operation queue; the back end
// applies it from there and registers its result for the result channel.
// Throughput: one event per cycle while the result channel takes results.
// Reset: synchronous; clears the slot table, the queue and the result valid,
// and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dect_slot_table_tracker_core #(
   parameter int HALF_FRAME = 12
) (
   input logic       clock,
   input logic       reset,
   dstt_req_if.sink  req_if,
   dstt_rsp_if.source rsp_if,
   dstt_csr_if.sink  csr_if
);
   import dstt_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  front_op;
   op_type  queue_op;
   logic    push;
   logic    full;
   logic    q_valid;
   logic    pop;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_ERROR_LIMIT:     cfg_in.error_limit     = csr_if.data[7:0];
            CSR_LAST_CHANNEL:    cfg_in.last_channel    = csr_if.data[5:0];
            CSR_FIXED_PART_SYNC: cfg_in.fixed_part_sync = csr_if.data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_limit     <= ERROR_LIMIT_RESET;
         cfg_ff.last_channel    <= LAST_CHANNEL_RESET;
         cfg_ff.fixed_part_sync <= FIXED_PART_SYNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dstt_front #(
      .HALF_FRAME(HALF_FRAME)
   ) u_front (
      .cfg (cfg_ff),
      .req (req_if),
      .full(full),
      .push(push),
      .op  (front_op)
   );

   dstt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .wr_op(front_op),
      .full (full),
      .pop  (pop),
      .valid(q_valid),
      .rd_op(queue_op)
   );

   dstt_back #(
      .HALF_FRAME(HALF_FRAME)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_valid(q_valid),
      .op     (queue_op),
      .pop    (pop),
      .rsp    (rsp_if)
   );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Slot table tracker testbench
// Drives event transactions into the tracker core through valid/ready
// channels, with random idle gaps on both sides and register writes between
// phases. A slot table model predicts every result but a pinned row's. Each
// result transaction is compared field by field with the oldest prediction.
// A short directed table comes first, then about 1200 random events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dstt_pkg::*;

   localparam int HALF_FRAME      = 12;
   localparam int NUM_SLOTS       = 2 * HALF_FRAME;
   localparam int NUM_PHASES      = 5;
   localparam int PHASE_ITEMS     = 240;
   localparam int CALM_ITEMS      = 40;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int BURST_ITEMS     = 24;
   localparam int SETTLE_CYCLES   = 10;
   localparam int N_DIRECTED      = 23;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam logic       ROW_PINNED    = 1'b1;
   localparam logic       ROW_PREDICTED = 1'b0;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] slot;
      logic [7:0] sync_high;
      logic [7:0] sync_low;
      logic [7:0] a_header;
      logic [7:0] tail_head;
      logic [7:0] info_byte;
      logic [7:0] info_data;
   } slot_event_type;

   typedef struct packed {
      logic        changed;
      logic        slot_active;
      logic        slot_scanning;
      logic [7:0]  slot_channel;
      logic [23:0] update_mask;
   } slot_report_type;

   typedef struct packed {
      slot_event_type  ev;
      logic            pinned;
      slot_report_type report;
   } directed_row_type;

   localparam slot_report_type BLANK_REPORT = '0;

   logic clock = 1'b0;
   logic reset;

   dstt_req_if req_bus ();
   dstt_rsp_if rsp_bus ();
   dstt_csr_if csr_bus ();

   dect_slot_table_tracker_core #(.HALF_FRAME(HALF_FRAME)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Slot table as the block should hold it.
   logic        tbl_active [NUM_SLOTS];
   logic        tbl_scan   [NUM_SLOTS];
   logic [7:0]  tbl_chan   [NUM_SLOTS];
   logic [7:0]  tbl_errs   [NUM_SLOTS];
   logic        tbl_mark   [NUM_SLOTS];
   logic [7:0]  lim_errors;
   logic [5:0]  wrap_channel;
   logic [15:0] fp_sync;

   slot_report_type pending_reports [$];
   int              mismatch_count = 0;
   logic            row_pinned;
   slot_report_type row_report;
   logic            idle_on = 1'b0;
   logic            hold_off_pending = 1'b0;
   int              error_focus = 0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      {CMD_ERROR,  5'd5,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROW_PINNED, BLANK_REPORT},
      {CMD_ERROR,  5'd31, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, ROW_PINNED, BLANK_REPORT},
      {CMD_TICK,   5'd0,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROW_PINNED, BLANK_REPORT},
      {CMD_UNUSED, 5'd7,  8'h55, 8'haa, 8'he0, 8'h00, 8'h2f, 8'hff, ROW_PINNED, BLANK_REPORT},
      {CMD_PACKET, 5'd0,  8'h00, 8'h00, 8'he0, 8'h00, 8'h2f, 8'hff, ROW_PINNED, BLANK_REPORT},
      {CMD_PACKET, 5'd3,  8'he9, 8'h8a, 8'he0, 8'h00, 8'h2f, 8'hff, ROW_PINNED,
       {1'b1, 1'b1, 1'b0, 8'h3f, 24'h008008}},
      {CMD_PACKET, 5'd0,  8'he9, 8'h8a, 8'hff, 8'h90, 8'h1f, 8'hff, ROW_PREDICTED, BLANK_REPORT},
      {CMD_TICK,   5'd1,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd1,  8'he9, 8'h8a, 8'h9f, 8'h0f, 8'h00, 8'hff, ROW_PREDICTED, BLANK_REPORT},
      {CMD_TICK,   5'd2,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd13, 8'he9, 8'h8b, 8'he0, 8'h00, 8'h2f, 8'hff, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd2,  8'he9, 8'h8a, 8'he0, 8'h20, 8'h2f, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd4,  8'he9, 8'h8a, 8'he0, 8'h10, 8'h10, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd5,  8'he9, 8'h8a, 8'he0, 8'h00, 8'h30, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd6,  8'he9, 8'h8a, 8'ha0, 8'h00, 8'h20, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd7,  8'he9, 8'h8a, 8'h80, 8'h10, 8'h00, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_ERROR,  5'd3,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd11, 8'he9, 8'h8a, 8'he0, 8'h00, 8'h10, 8'h01, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd11, 8'he9, 8'h8a, 8'he0, 8'h00, 8'h2b, 8'h40, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd30, 8'he9, 8'h8a, 8'he0, 8'h00, 8'h2c, 8'h3f, ROW_PREDICTED, BLANK_REPORT},
      {CMD_UNUSED, 5'd30, 8'he9, 8'h8a, 8'h80, 8'h00, 8'h00, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_ERROR,  5'd23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ROW_PREDICTED, BLANK_REPORT},
      {CMD_PACKET, 5'd31, 8'he9, 8'h8a, 8'he0, 8'h10, 8'h1f, 8'hff, ROW_PREDICTED, BLANK_REPORT}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Slot table prediction
   // ------------------------------------------------------------------
   function automatic void to_carrier(input int s);
      tbl_scan[s] = 1'b0;
      tbl_chan[s] = (tbl_chan[s] == 8'd0) ? {2'b00, wrap_channel} : tbl_chan[s] - 8'd1;
      tbl_errs[s] = 8'd0;
      tbl_mark[s] = 1'b1;
   endfunction

   function automatic void seat_bearer(input int s, input logic [7:0] ch);
      tbl_active[s] = 1'b1;
      tbl_chan[s]   = ch;
      tbl_scan[s]   = 1'b0;
      tbl_errs[s]   = 8'd0;
      tbl_mark[s]   = 1'b1;
   endfunction

   function automatic logic open_scan_slot(input int s);
      if (tbl_active[s])
         return 1'b0;
      tbl_active[s] = 1'b1;
      tbl_chan[s]   = 8'd0;
      tbl_scan[s]   = 1'b1;
      tbl_errs[s]   = 8'd0;
      tbl_mark[s]   = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic packet_update(input slot_event_type ev);
      logic        hit;
      int          s;
      int          pair_slot;
      logic [11:0] scan_map;
      hit = 1'b0;
      s = int'(ev.slot);
      if (s < NUM_SLOTS && tbl_scan[s]) begin
         pair_slot = (s >= HALF_FRAME) ? s - HALF_FRAME : s + HALF_FRAME;
         to_carrier(s);
         to_carrier(pair_slot);
      end
      if ({ev.sync_high, ev.sync_low} != fp_sync)
         return 1'b0;
      if ((ev.a_header & TAIL_TYPE_MASK) == TAIL_TYPE_P) begin
         if ((ev.tail_head & PAGE_HEAD_MASK) != PAGE_HEAD_ZERO &&
             (ev.tail_head & PAGE_HEAD_MASK) != PAGE_HEAD_ONE)
            return 1'b0;
         if (ev.info_byte[7:4] == INFO_BEARER) begin
            s = int'(ev.info_byte[3:0]) % HALF_FRAME;
            seat_bearer(s, {2'b00, ev.info_data[5:0]});
            seat_bearer(s + HALF_FRAME, {2'b00, ev.info_data[5:0]});
            return 1'b1;
         end
         if (ev.info_byte[7:4] == INFO_BITMAP) begin
            scan_map = {ev.info_byte[3:0], ev.info_data};
            for (int i = 0; i < HALF_FRAME && i < BITMAP_W; i++) begin
               if (scan_map[BITMAP_W-1-i]) begin
                  if (open_scan_slot(i))
                     hit = 1'b1;
                  if (open_scan_slot(i + HALF_FRAME))
                     hit = 1'b1;
               end
            end
            return hit;
         end
      end else if ((ev.a_header & TAIL_TYPE_MASK) == TAIL_TYPE_Q) begin
         if (ev.tail_head[7:4] == Q_HEAD_STATIC) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (tbl_active[i] && tbl_scan[i]) begin
                  tbl_chan[i] = ev.info_data;
                  tbl_mark[i] = 1'b1;
                  hit = 1'b1;
               end
            end
         end
      end
      return hit;
   endfunction

   function automatic logic error_update(input int s);
      if (s >= NUM_SLOTS)
         return 1'b0;
      if (tbl_errs[s] != 8'hff)
         tbl_errs[s] = tbl_errs[s] + 8'd1;
      if (!tbl_scan[s] && tbl_errs[s] > lim_errors) begin
         tbl_active[s] = 1'b0;
         tbl_mark[s]   = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic tick_update();
      logic hit;
      int   next_chan;
      hit = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (tbl_active[i] && tbl_scan[i]) begin
            next_chan = int'(tbl_chan[i]) + 1;
            tbl_chan[i] = (next_chan > int'(wrap_channel)) ? 8'd0 : next_chan[7:0];
            tbl_mark[i] = 1'b1;
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic slot_report_type apply_event(input slot_event_type ev);
      slot_report_type rep;
      int              s;
      rep = '0;
      s = int'(ev.slot);
      case (ev.cmd)
         CMD_PACKET: rep.changed = packet_update(ev);
         CMD_ERROR:  rep.changed = error_update(s);
         CMD_TICK:   rep.changed = tick_update();
         default:    rep.changed = 1'b0;
      endcase
      if (s < NUM_SLOTS) begin
         rep.slot_active   = tbl_active[s];
         rep.slot_scanning = tbl_scan[s];
         rep.slot_channel  = tbl_chan[s];
      end
      for (int i = 0; i < NUM_SLOTS && i < MASK_W; i++)
         rep.update_mask[i] = tbl_mark[i];
      return rep;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if (idle_on && $urandom_range(0, 99) < 35)
         return idle_length();
      return 0;
   endfunction

   function automatic slot_event_type random_event();
      slot_event_type ev;
      int             pick;
      int             s;
      pick = $urandom_range(0, 99);
      ev.cmd       = CMD_PACKET;
      ev.slot      = ($urandom_range(0, 99) < 92) ? 5'($urandom_range(0, NUM_SLOTS - 1))
                                                  : 5'($urandom_range(NUM_SLOTS, 31));
      ev.sync_high = 8'($urandom_range(0, 255));
      ev.sync_low  = 8'($urandom_range(0, 255));
      ev.a_header  = 8'($urandom_range(0, 255));
      ev.tail_head = 8'($urandom_range(0, 255));
      ev.info_byte = 8'($urandom_range(0, 255));
      ev.info_data = 8'($urandom_range(0, 255));
      if (pick < 30) begin
         {ev.sync_high, ev.sync_low} = fp_sync;
         ev.a_header[7:5]  = 3'b111;
         ev.tail_head[6:5] = 2'b00;
         ev.info_byte[7:4] = (pick < 18) ? INFO_BEARER : INFO_BITMAP;
      end else if (pick < 42) begin
         {ev.sync_high, ev.sync_low} = fp_sync;
         ev.a_header[7:5]  = 3'b100;
         ev.tail_head[7:4] = Q_HEAD_STATIC;
      end else if (pick < 52) begin
         for (int tries = 0; tries < 8; tries++) begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            if (tbl_scan[s]) begin
               ev.slot = 5'(s);
               break;
            end
         end
         if ($urandom_range(0, 1) == 0)
            {ev.sync_high, ev.sync_low} = fp_sync;
      end else if (pick < 60) begin
         ev.cmd = CMD_PACKET;
      end else if (pick < 85) begin
         ev.cmd = CMD_ERROR;
         if ($urandom_range(0, 99) < 25)
            error_focus = $urandom_range(0, NUM_SLOTS - 1);
         if ($urandom_range(0, 99) < 90)
            ev.slot = 5'(error_focus);
      end else if (pick < 95) begin
         ev.cmd = CMD_TICK;
      end else begin
         ev.cmd = CMD_UNUSED;
      end
      return ev;
   endfunction

   task automatic send_event(input slot_event_type ev, input logic pinned,
                             input slot_report_type report, input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= ev.cmd;
      req_bus.slot      <= ev.slot;
      req_bus.sync_high <= ev.sync_high;
      req_bus.sync_low  <= ev.sync_low;
      req_bus.a_header  <= ev.a_header;
      req_bus.tail_head <= ev.tail_head;
      req_bus.info_byte <= ev.info_byte;
      req_bus.info_data <= ev.info_data;
      row_pinned        <= pinned;
      row_report        <= report;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [15:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic check_field(input string label, input logic [23:0] want,
                              input logic [23:0] seen);
      if (seen !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, seen);
      end
   endtask

   // ------------------------------------------------------------------
   // Result receiver with random stalls
   // ------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Transaction monitor: predicts on accepted events, checks results
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      slot_event_type  seen_event;
      slot_report_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transaction, expected none, actual %0h",
                        $time, {rsp_bus.changed, rsp_bus.slot_active, rsp_bus.slot_scanning,
                                rsp_bus.slot_channel, rsp_bus.update_mask});
            end else begin
               want = pending_reports.pop_front();
               check_field("changed", 24'(want.changed), 24'(rsp_bus.changed));
               check_field("slot_active", 24'(want.slot_active), 24'(rsp_bus.slot_active));
               check_field("slot_scanning", 24'(want.slot_scanning),
                           24'(rsp_bus.slot_scanning));
               check_field("slot_channel", 24'(want.slot_channel),
                           24'(rsp_bus.slot_channel));
               check_field("update_mask", want.update_mask, rsp_bus.update_mask);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_ERROR_LIMIT:     lim_errors   = csr_bus.data[7:0];
               CSR_LAST_CHANNEL:    wrap_channel = csr_bus.data[5:0];
               CSR_FIXED_PART_SYNC: fp_sync      = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_event.cmd       = req_bus.cmd;
            seen_event.slot      = req_bus.slot;
            seen_event.sync_high = req_bus.sync_high;
            seen_event.sync_low  = req_bus.sync_low;
            seen_event.a_header  = req_bus.a_header;
            seen_event.tail_head = req_bus.tail_head;
            seen_event.info_byte = req_bus.info_byte;
            seen_event.info_data = req_bus.info_data;
            want = apply_event(seen_event);
            if (row_pinned)
               want = row_report;
            pending_reports.push_back(want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_sequence
      logic [7:0]  phase_limit;
      logic [5:0]  phase_channel;
      logic [15:0] phase_sync;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_PACKET;
      req_bus.slot      = '0;
      req_bus.sync_high = '0;
      req_bus.sync_low  = '0;
      req_bus.a_header  = '0;
      req_bus.tail_head = '0;
      req_bus.info_byte = '0;
      req_bus.info_data = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_ERROR_LIMIT;
      csr_bus.data      = '0;
      row_pinned        = ROW_PREDICTED;
      row_report        = BLANK_REPORT;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tbl_active[i] = 1'b0;
         tbl_scan[i]   = 1'b0;
         tbl_chan[i]   = 8'd0;
         tbl_errs[i]   = 8'd0;
         tbl_mark[i]   = 1'b0;
      end
      lim_errors   = ERROR_LIMIT_RESET;
      wrap_channel = LAST_CHANNEL_RESET;
      fp_sync      = FIXED_PART_SYNC_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      for (int i = 0; i < N_DIRECTED; i++)
         send_event(directed_rows[i].ev, directed_rows[i].pinned, directed_rows[i].report,
                    sender_gap());

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: begin
                  phase_limit = 8'd0;
                  phase_channel = 6'd0;
                  phase_sync = 16'h0000;
               end
               2: begin
                  phase_limit = 8'd254;
                  phase_channel = 6'd63;
                  phase_sync = 16'hffff;
               end
               3: begin
                  phase_limit = 8'd3;
                  phase_channel = 6'd5;
                  phase_sync = 16'($urandom_range(0, 65535));
               end
               default: begin
                  phase_limit = 8'd10;
                  phase_channel = LAST_CHANNEL_RESET;
                  phase_sync = FIXED_PART_SYNC_RESET;
               end
            endcase
            wait_for_results();
            write_register(CSR_ERROR_LIMIT, {8'h00, phase_limit});
            write_register(CSR_LAST_CHANNEL, {10'h000, phase_channel});
            write_register(CSR_FIXED_PART_SYNC, phase_sync);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idle_on = (n >= CALM_ITEMS);
            if (phase == 1 && n == 100) begin
               hold_off_pending = 1'b1;
               for (int k = 0; k < BURST_ITEMS; k++)
                  send_event(random_event(), ROW_PREDICTED, BLANK_REPORT, 0);
            end
            if (phase == 3 && n == 120)
               wait_for_results();
            send_event(random_event(), ROW_PREDICTED, BLANK_REPORT, sender_gap());
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: dect_slot_table_tracker_core.f
+incdir+sv
sv/dstt_pkg.sv
sv/dstt_req_if.sv
sv/dstt_rsp_if.sv
sv/dstt_csr_if.sv
sv/dstt_front.sv
sv/dstt_queue.sv
sv/dstt_back.sv
sv/dect_slot_table_tracker_core.sv
tb/tb_top.sv
